// File: rtl/ffa_pkg.sv
// shared constants, request/result types and control structs of the first-fit unit allocator
// no dependencies
package ffa_pkg;

	// map geometry: unit count is a power of two, at least two map words
	localparam int UNIT_COUNT = 1024;
	localparam int WORD_W     = 32;
	localparam int WORDS      = UNIT_COUNT / WORD_W;
	localparam int WA_W       = $clog2(WORDS);
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int PW         = $clog2(UNIT_COUNT);
	localparam int RW         = (PW + 2 > 12) ? PW + 2 : 12;

	// fixed field widths
	localparam int COUNT_W = 11;
	localparam int START_W = 10;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [COUNT_W-1:0] unit_count;
		logic [START_W-1:0] free_start;
	} req_t;

	typedef struct packed {
		logic               success;
		logic [START_W-1:0] alloc_start;
	} rsp_t;

	// control from sequencer to scanner
	typedef struct packed {
		logic            clear;
		logic            en;
		logic [WA_W-1:0] word;
		logic [RW-1:0]   len;
	} scan_ctl_t;

	// scanner status back to sequencer
	typedef struct packed {
		logic          found;
		logic          exhausted;
		logic [PW-1:0] end_pos;
	} scan_sts_t;

endpackage

// File: rtl/ffa_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/ffa_scan.sv
// first-fit scanner: evaluates one map word per cycle, carries the free run across words
// depends on ffa_pkg
module ffa_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffa_pkg::scan_ctl_t            ctl,
	input  logic [ffa_pkg::WORD_W-1:0]    used,
	output ffa_pkg::scan_sts_t            sts
);

	logic [ffa_pkg::RW-1:0]     carry_q;
	logic                       found_q;
	logic                       exhausted_q;
	logic [ffa_pkg::PW-1:0]     end_pos_q;

	logic [ffa_pkg::WORD_W-1:0] top_mask;
	logic [ffa_pkg::WORD_W-1:0] hit;
	logic [ffa_pkg::WORD_W-1:0] used_rev;
	logic [ffa_pkg::BIT_W-1:0]  hit_pos;
	logic [ffa_pkg::BIT_W-1:0]  lead_free;
	logic [ffa_pkg::RW-1:0]     carry_nxt;
	logic                       live;

	function automatic logic [ffa_pkg::BIT_W-1:0] enc_low(input logic [ffa_pkg::WORD_W-1:0] v);
		logic [ffa_pkg::WORD_W-1:0] iso;
		logic [ffa_pkg::BIT_W-1:0]  idx;
		iso = v & (~v + 1'b1);
		idx = '0;
		for (int i = 0; i < ffa_pkg::WORD_W; i++) begin
			if (iso[i]) begin
				idx = idx | ffa_pkg::BIT_W'(i);
			end
		end
		return idx;
	endfunction

	// top len bits set, all bits once len covers the word
	assign top_mask = ~({ffa_pkg::WORD_W{1'b1}} >> ctl.len);

	// bit p ends a fitting run when the len bits up to p are free and the
	// run reaching in from lower words is long enough
	always_comb begin
		for (int p = 0; p < ffa_pkg::WORD_W; p++) begin
			hit[p] = (((used << (ffa_pkg::WORD_W - 1 - p)) & top_mask) == '0)
				&& ((carry_q + ffa_pkg::RW'(p) + ffa_pkg::RW'(1)) >= ctl.len);
		end
	end

	always_comb begin
		for (int i = 0; i < ffa_pkg::WORD_W; i++) begin
			used_rev[i] = used[ffa_pkg::WORD_W - 1 - i];
		end
	end

	assign hit_pos   = enc_low(hit);
	assign lead_free = enc_low(used_rev);
	assign carry_nxt = (used == '0) ? carry_q + ffa_pkg::RW'(ffa_pkg::WORD_W)
		: ffa_pkg::RW'(lead_free);
	assign live = ctl.en && !found_q && !exhausted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q     <= '0;
			found_q     <= 1'b0;
			exhausted_q <= 1'b0;
		end else if (ctl.clear) begin
			carry_q     <= '0;
			found_q     <= 1'b0;
			exhausted_q <= 1'b0;
		end else if (live) begin
			if (|hit) begin
				found_q <= 1'b1;
			end else begin
				carry_q <= carry_nxt;
				if (ctl.word == ffa_pkg::WA_W'(ffa_pkg::WORDS - 1)) begin
					exhausted_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (live && (|hit)) begin
			end_pos_q <= {ctl.word, hit_pos};
		end
	end

	assign sts.found     = found_q;
	assign sts.exhausted = exhausted_q;
	assign sts.end_pos   = end_pos_q;

endmodule

// File: rtl/first_fit_unit_allocator_core.sv
// top level of the first-fit unit allocator: sequencer, map ram and scanner
// depends on ffa_pkg, ffa_ram, ffa_scan
//
// channel   direction  handshake                 payload
// request   in         start high, busy low      req (ffa_pkg::req_t)
// result    out        done strobe, one cycle    rsp (ffa_pkg::rsp_t)
//
// the used map sits in a 32 x 32 ram, read one word per cycle; that port sets the rate
// allocate: scan words from the bottom until a run fits, then read-modify-write the
//   covered words; a request that fits nowhere fails once the top map word is scanned
// free: clear the covered words; zero size, oversized allocate or nothing to free answer at once
// after reset a clearing pass writes every map word free, busy is high meanwhile
// the receiver cannot stall: each result is shown for one cycle with done high
module first_fit_unit_allocator_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ffa_pkg::req_t   req,
	output logic            done,
	output ffa_pkg::rsp_t   rsp
);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_MARK  = 4'b1000
	} state_t;

	// control state
	state_t                   state_q, state_d;
	logic [ffa_pkg::WA_W-1:0] rd_ptr_q, rd_ptr_d;
	logic                     rd_more_q, rd_more_d;
	logic                     dvalid_s1, dvalid_d;
	logic                     done_q, done_d;

	// payload
	logic [ffa_pkg::WA_W-1:0] word_s1;
	logic [ffa_pkg::RW-1:0]   len_q, len_d;
	logic                     set_q, set_d;
	logic [ffa_pkg::PW-1:0]   lo_q, lo_d;
	logic [ffa_pkg::PW-1:0]   hi_q, hi_d;
	ffa_pkg::rsp_t            rsp_q, rsp_d;

	// ram side
	logic                       ram_we;
	logic [ffa_pkg::WA_W-1:0]   ram_waddr;
	logic [ffa_pkg::WORD_W-1:0] ram_wdata;
	logic [ffa_pkg::WORD_W-1:0] ram_rdata;
	logic                       rd_issue;

	ffa_pkg::scan_ctl_t scan_ctl;
	ffa_pkg::scan_sts_t scan_sts;

	logic                       accept;
	logic [ffa_pkg::RW-1:0]     req_len;
	logic [ffa_pkg::RW-1:0]     req_first;
	logic [ffa_pkg::RW-1:0]     free_last;
	logic [ffa_pkg::RW-1:0]     run_lo;
	logic [ffa_pkg::WA_W-1:0]   lo_word;
	logic [ffa_pkg::WA_W-1:0]   hi_word;
	logic [ffa_pkg::BIT_W-1:0]  lo_bit;
	logic [ffa_pkg::BIT_W-1:0]  hi_bit;
	logic [ffa_pkg::WORD_W-1:0] word_mask;
	logic                       mark_last;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign req_len   = ffa_pkg::RW'(req.unit_count);
	assign req_first = ffa_pkg::RW'(req.free_start);
	assign free_last = req_first + req_len - ffa_pkg::RW'(1);
	// start of the found run from its last unit
	assign run_lo    = ffa_pkg::RW'(scan_sts.end_pos) + ffa_pkg::RW'(1) - len_q;

	assign lo_word = lo_q[ffa_pkg::PW-1:ffa_pkg::BIT_W];
	assign hi_word = hi_q[ffa_pkg::PW-1:ffa_pkg::BIT_W];

	// reads run in scan and mark while words remain to be fetched
	assign rd_issue = ((state_q == S_SCAN) || (state_q == S_MARK)) && rd_more_q;

	// bits of the word in flight that fall inside [lo, hi]
	assign lo_bit    = (word_s1 == lo_word) ? lo_q[ffa_pkg::BIT_W-1:0] : '0;
	assign hi_bit    = (word_s1 == hi_word) ? hi_q[ffa_pkg::BIT_W-1:0] : '1;
	assign word_mask = ({ffa_pkg::WORD_W{1'b1}} << lo_bit)
		& ({ffa_pkg::WORD_W{1'b1}} >> (~hi_bit));

	assign mark_last = (state_q == S_MARK) && dvalid_s1 && (word_s1 == hi_word);

	// write port: clearing pass, or write back of the marked word
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = word_s1;
		ram_wdata = set_q ? (ram_rdata | word_mask) : (ram_rdata & ~word_mask);
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = rd_ptr_q;
			ram_wdata = '0;
		end else if ((state_q == S_MARK) && dvalid_s1) begin
			ram_we = 1'b1;
		end
	end

	ffa_ram #(
		.WIDTH (ffa_pkg::WORD_W),
		.DEPTH (ffa_pkg::WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	assign scan_ctl.clear = accept;
	assign scan_ctl.en    = (state_q == S_SCAN) && dvalid_s1;
	assign scan_ctl.word  = word_s1;
	assign scan_ctl.len   = len_q;

	ffa_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.used   (ram_rdata),
		.sts    (scan_sts)
	);

	// sequencer
	always_comb begin
		state_d   = state_q;
		rd_ptr_d  = rd_ptr_q;
		rd_more_d = rd_more_q;
		dvalid_d  = rd_issue;
		done_d    = 1'b0;
		len_d     = len_q;
		set_d     = set_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		rsp_d     = rsp_q;

		// advance the read pointer on each issued read
		if (rd_issue) begin
			rd_ptr_d = rd_ptr_q + 1'b1;
		end

		unique case (state_q)
			S_CLEAR: begin
				rd_ptr_d = rd_ptr_q + 1'b1;
				if (rd_ptr_q == ffa_pkg::WA_W'(ffa_pkg::WORDS - 1)) begin
					state_d  = S_IDLE;
					rd_ptr_d = '0;
				end
			end
			S_IDLE: begin
				if (accept) begin
					len_d = req_len;
					if (req.mode == ffa_pkg::MODE_ALLOC) begin
						set_d = 1'b1;
						if ((req_len == '0)
							|| (req_len > ffa_pkg::RW'(ffa_pkg::UNIT_COUNT))) begin
							// empty or oversized request fails at once
							done_d = 1'b1;
							rsp_d  = '0;
						end else begin
							state_d   = S_SCAN;
							rd_ptr_d  = '0;
							rd_more_d = 1'b1;
						end
					end else begin
						set_d = 1'b0;
						if ((req_len == '0)
							|| (req_first >= ffa_pkg::RW'(ffa_pkg::UNIT_COUNT))) begin
							// nothing inside the map to free
							done_d            = 1'b1;
							rsp_d.success     = 1'b1;
							rsp_d.alloc_start = '0;
						end else begin
							lo_d = ffa_pkg::PW'(req_first);
							// cut the run off at the end of the map
							if (free_last >= ffa_pkg::RW'(ffa_pkg::UNIT_COUNT)) begin
								hi_d = ffa_pkg::PW'(ffa_pkg::UNIT_COUNT - 1);
							end else begin
								hi_d = ffa_pkg::PW'(free_last);
							end
							state_d   = S_MARK;
							rd_ptr_d  = req_first[ffa_pkg::PW-1:ffa_pkg::BIT_W];
							rd_more_d = 1'b1;
						end
					end
				end
			end
			S_SCAN: begin
				if (rd_issue && (rd_ptr_q == ffa_pkg::WA_W'(ffa_pkg::WORDS - 1))) begin
					rd_more_d = 1'b0;
				end
				if (scan_sts.found) begin
					// drop reads in flight and restart at the run's first word
					lo_d      = ffa_pkg::PW'(run_lo);
					hi_d      = scan_sts.end_pos;
					state_d   = S_MARK;
					rd_ptr_d  = run_lo[ffa_pkg::PW-1:ffa_pkg::BIT_W];
					rd_more_d = 1'b1;
					dvalid_d  = 1'b0;
				end else if (scan_sts.exhausted) begin
					state_d   = S_IDLE;
					rd_more_d = 1'b0;
					dvalid_d  = 1'b0;
					done_d    = 1'b1;
					rsp_d     = '0;
				end
			end
			S_MARK: begin
				if (rd_issue && (rd_ptr_q == hi_word)) begin
					rd_more_d = 1'b0;
				end
				if (mark_last) begin
					state_d       = S_IDLE;
					dvalid_d      = 1'b0;
					done_d        = 1'b1;
					rsp_d.success = 1'b1;
					rsp_d.alloc_start = set_q
						? ffa_pkg::START_W'(ffa_pkg::RW'(lo_q)) : '0;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			rd_ptr_q  <= '0;
			rd_more_q <= 1'b0;
			dvalid_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_ptr_q  <= rd_ptr_d;
			rd_more_q <= rd_more_d;
			dvalid_s1 <= dvalid_d;
			done_q    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= rd_ptr_q;
		len_q   <= len_d;
		set_q   <= set_d;
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		rsp_q   <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	// the map is only written while the block is busy
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !ram_we)
		else $error("map written while idle");

	// read-modify-write never reads the word it is writing back
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_MARK) && rd_issue && ram_we) |-> (rd_ptr_q != ram_waddr))
		else $error("read and write of the same map word");

	// marked range is ordered
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> (lo_q <= hi_q))
		else $error("mark range reversed");

	// scanner never reports a fit and an exhausted map together
	a_scan_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(scan_sts.found && scan_sts.exhausted))
		else $error("scanner found and exhausted at once");

	// an empty allocate fails on the next cycle
	a_zero_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.mode == ffa_pkg::MODE_ALLOC) && (req.unit_count == '0))
		|=> (done && !rsp.success))
		else $error("empty allocate not failed at once");
`endif

endmodule
